FILE: src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, constants and helpers for the plane rotate/reflect tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int COORD_WIDTH = 32;  // input coordinate width, 8..62
    localparam int OUT_WIDTH   = 64;  // offsets and results wrap modulo 2^64

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [OUT_WIDTH-1:0]          t_wide;

    typedef enum logic [2:0] {
        FUNC_QUERY   = 3'd0,
        FUNC_ROT_CW  = 3'd1,
        FUNC_ROT_CCW = 3'd2,
        FUNC_REFL_X  = 3'd3,
        FUNC_REFL_Y  = 3'd4
    } t_func;

    // running transform: signs/offsets first, then quarter turns
    typedef struct packed {
        logic [1:0] orient;
        t_wide      off_x;
        t_wide      off_y;
        logic       flip_x;
        logic       flip_y;
    } t_xform;

    function automatic t_wide sext_coord(input t_coord v);
        return {{(OUT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

endpackage

FILE: src/plane_rotate_reflect_tracker.sv
// ----------------------------------------------------------------------------
// plane_rotate_reflect_tracker
// Running quarter-turn / mirror transform of the plane with point queries.
// ----------------------------------------------------------------------------
// Each input word is either an operation (rotate cw/ccw, reflect across x=p
// or y=p) or a point query. Operations update the stored transform and give
// no output word; a query returns the point mapped through every earlier
// operation, 64-bit two's complement, wrapping. Throughput is one word per
// cycle while input ready is high; a query's result passes through the input
// register, then the result register. Input ready drops only when a query sits
// in the input register while the result register is full and not taken.
// Unused func codes are consumed silently.
// ----------------------------------------------------------------------------
module plane_rotate_reflect_tracker
    import prt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  t_coord             i_line_pos,
    input  t_coord             i_point_x,
    input  t_coord             i_point_y,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_mapped_x,
    output logic signed [63:0] o_mapped_y
);

    // input register
    logic       r_in_vld;
    logic [2:0] r_func;
    t_coord     r_line_pos;
    t_coord     r_point_x;
    t_coord     r_point_y;

    // result register
    logic       r_out_vld;
    t_wide      r_mapped_x;
    t_wide      r_mapped_y;

    logic       w_is_query;
    logic       w_out_free;
    logic       w_adv;
    logic       w_in_acc;
    t_xform     w_xform;
    t_wide      w_map_x;
    t_wide      w_map_y;

    assign w_is_query = (r_func == FUNC_QUERY);
    assign w_out_free = !r_out_vld || i_ready;
    // the held word retires when it is an op, or the result slot is open
    assign w_adv      = r_in_vld && (!w_is_query || w_out_free);
    assign o_ready    = !r_in_vld || w_adv;
    assign w_in_acc   = i_valid && o_ready;

    prt_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_en    (w_adv),
        .i_func     (r_func),
        .i_line_pos (r_line_pos),
        .o_xform    (w_xform)
    );

    prt_map u_map (
        .i_xform    (w_xform),
        .i_point_x  (r_point_x),
        .i_point_y  (r_point_y),
        .o_mapped_x (w_map_x),
        .o_mapped_y (w_map_y)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv && w_is_query) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func     <= i_func;
            r_line_pos <= i_line_pos;
            r_point_x  <= i_point_x;
            r_point_y  <= i_point_y;
        end
        if (w_adv && w_is_query) begin
            r_mapped_x <= w_map_x;
            r_mapped_y <= w_map_y;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_mapped_x = r_mapped_x;
    assign o_mapped_y = r_mapped_y;

endmodule

FILE: src/prt_state.sv
// ----------------------------------------------------------------------------
// prt_state
// Holds the running transform and applies rotate / reflect operations.
// ----------------------------------------------------------------------------
module prt_state
    import prt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_en,
    input  logic [2:0]  i_func,
    input  t_coord      i_line_pos,
    output t_xform      o_xform
);

    t_xform r_xf;
    t_xform n_xf;

    logic  w_on_x;
    logic  w_neg;
    t_wide w_p;
    t_wide w_twop;
    t_wide w_kp;

    always_comb begin
        n_xf   = r_xf;
        w_p    = sext_coord(i_line_pos);
        w_twop = {w_p[OUT_WIDTH-2:0], 1'b0};
        // mirror across x=p hits x in even orientations, y in odd
        w_on_x = (r_xf.orient[0] == 1'b0) == (i_func == FUNC_REFL_X);
        if (i_func == FUNC_REFL_X) begin
            w_neg = (r_xf.orient == 2'd1) || (r_xf.orient == 2'd2);
        end else begin
            w_neg = (r_xf.orient == 2'd2) || (r_xf.orient == 2'd3);
        end
        w_kp = w_neg ? (t_wide'(0) - w_twop) : w_twop;
        case (i_func) inside
            FUNC_ROT_CW:  n_xf.orient = r_xf.orient - 2'd1;
            FUNC_ROT_CCW: n_xf.orient = r_xf.orient + 2'd1;
            FUNC_REFL_X, FUNC_REFL_Y: begin
                if (w_on_x) begin
                    n_xf.off_x  = w_kp - r_xf.off_x;
                    n_xf.flip_x = ~r_xf.flip_x;
                end else begin
                    n_xf.off_y  = w_kp - r_xf.off_y;
                    n_xf.flip_y = ~r_xf.flip_y;
                end
            end
            default: ;  // query and unused codes leave state alone
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf <= '0;
        end else if (i_op_en) begin
            r_xf <= n_xf;
        end
    end

    assign o_xform = r_xf;

endmodule

FILE: src/prt_map.sv
// ----------------------------------------------------------------------------
// prt_map
// Maps a point through the current transform: sign/offset, then rotation.
// ----------------------------------------------------------------------------
module prt_map
    import prt_pkg::*;
(
    input  t_xform i_xform,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    output t_wide  o_mapped_x,
    output t_wide  o_mapped_y
);

    t_wide w_x;
    t_wide w_y;
    t_wide w_nx;
    t_wide w_ny;

    always_comb begin
        w_x  = sext_coord(i_point_x);
        w_y  = sext_coord(i_point_y);
        w_nx = i_xform.flip_x ? (i_xform.off_x - w_x) : (i_xform.off_x + w_x);
        w_ny = i_xform.flip_y ? (i_xform.off_y - w_y) : (i_xform.off_y + w_y);
        case (i_xform.orient)
            2'd0: begin
                o_mapped_x = w_nx;
                o_mapped_y = w_ny;
            end
            2'd1: begin
                o_mapped_x = t_wide'(0) - w_ny;
                o_mapped_y = w_nx;
            end
            2'd2: begin
                o_mapped_x = t_wide'(0) - w_nx;
                o_mapped_y = t_wide'(0) - w_ny;
            end
            default: begin
                o_mapped_x = w_ny;
                o_mapped_y = t_wide'(0) - w_nx;
            end
        endcase
    end

endmodule
